// ===== rtl/core/q8_group_dot_product_macros.svh =====
// Assertion macros shared by the q8 group dot product RTL.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef Q8_GROUP_DOT_PRODUCT_MACROS_SVH
`define Q8_GROUP_DOT_PRODUCT_MACROS_SVH

// Plain concurrent check, off while reset is asserted.
`define Q8_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define Q8_ASSERT_NXT(label, ante, cons, msg) \
	`Q8_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/q8gdp_pkg.sv =====
// Shared types and constants for the q8 group dot product.
// No dependencies; used by every module of the block.
`default_nettype none

package q8gdp_pkg;

	localparam int MAX_GROUP_DEF   = 256;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int GSIZE_W = 9;
	localparam logic [GSIZE_W-1:0] GSIZE_RST = 9'd32;

	localparam int GSUM_W  = 24;
	localparam int SCALE_W = 16;
	localparam int ROW_W   = 48;

	typedef struct packed {
		logic signed [7:0]     act_value;
		logic signed [7:0]     weight_value;
		logic [SCALE_W-1:0]    act_scale;
		logic [SCALE_W-1:0]    weight_scale;
		logic                  row_end;
	} in_item_t;

	typedef struct packed {
		logic signed [ROW_W-1:0] row_sum;
		logic                    saturated;
	} out_item_t;

	// Request from front to back: one finished group and/or a row end.
	typedef struct packed {
		logic signed [GSUM_W-1:0] gsum;
		logic [SCALE_W-1:0]       act_scale;
		logic [SCALE_W-1:0]       weight_scale;
		logic                     add_grp;
		logic                     row_end;
	} grp_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/q8_group_dot_product.sv =====
// q8 group dot product: one element pair per cycle in, one row result per row end.
// Path: a row end request passes the request queue, back-end stages s1, s2 and s3 and the result register.
// Throughput: one item per cycle; the front stalls only when the request queue is full,
// which happens only while a row result is held by out_stall.
// Reset: arst_n clears all row and group state; the group length returns to 32.
// Depends on q8gdp_pkg, q8gdp_front, q8gdp_fifo and q8gdp_back.
`default_nettype none

module q8_group_dot_product #(
	parameter int MAX_GROUP   = q8gdp_pkg::MAX_GROUP_DEF,
	parameter int QUEUE_DEPTH = q8gdp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [q8gdp_pkg::GSIZE_W-1:0] cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire q8gdp_pkg::in_item_t           in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output q8gdp_pkg::out_item_t               out_data
);

	q8gdp_pkg::grp_req_t q_wdata;
	q8gdp_pkg::grp_req_t q_rdata;
	logic                q_push;
	logic                q_pop;
	logic                q_full;
	logic                q_empty;

	q8gdp_front #(
		.MAX_GROUP (MAX_GROUP)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	q8gdp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	q8gdp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== rtl/core/q8gdp_front.sv =====
// Front end: accepts element pairs, runs the exact int8 MAC per group and
// issues group/row requests. Holds the group length register. Uses q8gdp_pkg.
`default_nettype none

module q8gdp_front #(
	parameter int MAX_GROUP = q8gdp_pkg::MAX_GROUP_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [q8gdp_pkg::GSIZE_W-1:0] cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire q8gdp_pkg::in_item_t           in_data,
	input  wire logic                          q_full,
	output logic                               q_push,
	output q8gdp_pkg::grp_req_t                q_wdata
);

	localparam int CNT_W = $clog2(MAX_GROUP + 1);
	localparam int CMP_W = (CNT_W > q8gdp_pkg::GSIZE_W) ? CNT_W : q8gdp_pkg::GSIZE_W;
	localparam logic [CMP_W-1:0] MAXG = CMP_W'(MAX_GROUP);

	logic [q8gdp_pkg::GSIZE_W-1:0]       grp_len_q;
	logic [CNT_W-1:0]                    count_q;
	logic signed [q8gdp_pkg::GSUM_W-1:0] gsum_q;

	logic [CMP_W-1:0]                    gs_ext;
	logic [CMP_W-1:0]                    eff;
	logic [CNT_W-1:0]                    cnt_inc;
	logic signed [15:0]                  prod;
	logic signed [q8gdp_pkg::GSUM_W-1:0] sum_next;
	logic                                grp_end;
	logic                                accept;

	assign gs_ext   = CMP_W'(grp_len_q);
	assign eff      = (gs_ext == '0 || gs_ext > MAXG) ? MAXG : gs_ext;
	assign cnt_inc  = count_q + CNT_W'(1);
	assign grp_end  = CMP_W'(cnt_inc) >= eff;
	assign prod     = in_data.act_value * in_data.weight_value;
	assign sum_next = gsum_q + {{(q8gdp_pkg::GSUM_W-16){prod[15]}}, prod};

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept && (grp_end || in_data.row_end);

	always_comb begin
		q_wdata.gsum         = sum_next;
		q_wdata.act_scale    = in_data.act_scale;
		q_wdata.weight_scale = in_data.weight_scale;
		q_wdata.add_grp      = grp_end;
		q_wdata.row_end      = in_data.row_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_len_q <= q8gdp_pkg::GSIZE_RST;
			count_q   <= '0;
			gsum_q    <= '0;
		end else begin
			if (cfg_we) begin
				grp_len_q <= cfg_wdata;
			end
			if (accept) begin
				// partial group at row end is dropped
				if (grp_end || in_data.row_end) begin
					count_q <= '0;
					gsum_q  <= '0;
				end else begin
					count_q <= cnt_inc;
					gsum_q  <= sum_next;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/q8gdp_fifo.sv =====
// Short request queue between front and back ends, flop based.
// Uses q8gdp_pkg for the request type and the assertion macros header.
`default_nettype none
`include "q8_group_dot_product_macros.svh"

module q8gdp_fifo #(
	parameter int DEPTH = q8gdp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire q8gdp_pkg::grp_req_t wdata,
	input  wire logic                pop,
	output q8gdp_pkg::grp_req_t      rdata,
	output logic                     full,
	output logic                     empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	q8gdp_pkg::grp_req_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wptr_q;
	logic [PTR_W-1:0]    rptr_q;
	logic [CNT_W-1:0]    count_q;

	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + PTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`Q8_ASSERT(a_no_push_full, !(push && full), "request pushed into full queue")
	`Q8_ASSERT(a_no_pop_empty, !(pop && empty), "request popped from empty queue")
	`Q8_ASSERT_NXT(a_pop_drains, pop && !push, count_q == $past(count_q) - CNT_W'(1), "queue count did not drop on pop")

endmodule

`default_nettype wire

// ===== rtl/core/q8gdp_back.sv =====
// Back end: scales each group sum, rounds, accumulates the row with
// saturation and holds the result register. Uses q8gdp_pkg and the macros.
`default_nettype none
`include "q8_group_dot_product_macros.svh"

module q8gdp_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_empty,
	input  wire q8gdp_pkg::grp_req_t q_rdata,
	output logic                     q_pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output q8gdp_pkg::out_item_t     out_data
);

	localparam int GW   = q8gdp_pkg::GSUM_W;
	localparam int SW   = q8gdp_pkg::SCALE_W;
	localparam int PW   = GW + 2 * SW;          // scaled product, 28 frac bits
	localparam int RW   = PW - 12 + 1;          // rounded magnitude incl. carry
	localparam int AW   = q8gdp_pkg::ROW_W;
	localparam int XW   = AW + 2;               // accumulate headroom
	localparam logic signed [XW-1:0] ACC_MAX = XW'({1'b0, {(AW-1){1'b1}}});
	localparam logic signed [XW-1:0] ACC_MIN = -ACC_MAX - XW'(1);

	logic v_s1, v_s2, v_s3;
	logic re_s1, re_s2, re_s3;
	logic add_s1, add_s2;
	logic neg_s1, neg_s2;
	logic [GW-1:0]          mag_s1;
	logic [2*SW-1:0]        sp_s1;
	logic [PW-1:0]          prod_s2;
	logic signed [XW-1:0]   term_s3;

	logic signed [AW-1:0]   acc_q;
	logic                   clip_q;
	logic                   out_valid_q;
	q8gdp_pkg::out_item_t   out_q;

	logic                   adv;
	logic                   head_neg;
	logic [PW:0]            rnd;
	logic [XW-1:0]          rmag;
	logic signed [XW-1:0]   sum;
	logic signed [AW-1:0]   acc_new;
	logic                   clip_now;

	// whole back end holds only when a row end in s3 meets a result still held by out_stall
	assign adv      = !(out_valid_q && out_stall && v_s3 && re_s3);
	assign q_pop    = !q_empty && adv;
	assign head_neg = q_rdata.gsum[GW-1];

	assign rnd  = {1'b0, prod_s2} + (PW+1)'(2048);
	assign rmag = XW'(rnd[PW:12]);

	always_comb begin
		sum      = XW'(acc_q) + term_s3;
		clip_now = 1'b0;
		acc_new  = AW'(sum);
		if (sum > ACC_MAX) begin
			acc_new  = AW'(ACC_MAX);
			clip_now = 1'b1;
		end else if (sum < ACC_MIN) begin
			acc_new  = AW'(ACC_MIN);
			clip_now = 1'b1;
		end
	end

	// datapath stages, no reset needed
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1  <= head_neg ? (~q_rdata.gsum + GW'(1)) : q_rdata.gsum;
			sp_s1   <= q_rdata.act_scale * q_rdata.weight_scale;
			neg_s1  <= head_neg;
			add_s1  <= q_rdata.add_grp;
			re_s1   <= q_rdata.row_end;
			prod_s2 <= {{(2*SW){1'b0}}, mag_s1} * {{GW{1'b0}}, sp_s1};
			neg_s2  <= neg_s1;
			add_s2  <= add_s1;
			re_s2   <= re_s1;
			if (!add_s2) begin
				term_s3 <= '0;
			end else begin
				term_s3 <= neg_s2 ? -$signed(rmag) : $signed(rmag);
			end
			re_s3   <= re_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			acc_q       <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv && v_s3 && re_s3) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				v_s1 <= q_pop;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				if (v_s3) begin
					if (re_s3) begin
						acc_q  <= '0;
						clip_q <= 1'b0;
					end else begin
						acc_q  <= acc_new;
						clip_q <= clip_q | clip_now;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3 && re_s3) begin
			out_q.row_sum   <= acc_new;
			out_q.saturated <= clip_q | clip_now;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`Q8_ASSERT(a_out_from_row, $rose(out_valid_q) |-> $past(v_s3 && re_s3 && adv), "stray result")
	`Q8_ASSERT_NXT(a_row_clears, adv && v_s3 && re_s3, acc_q == '0 && !clip_q, "row not cleared")
	`Q8_ASSERT_NXT(a_freeze, !adv, $stable(term_s3) && $stable(re_s3) && v_s3, "moved while held")

endmodule

`default_nettype wire

// ===== sim/q8_checker.sv =====
// Scoreboard for q8_group_dot_product: follows group length writes and accepted requests,
// predicts each row result and compares it with the block's output, field by field.
// Depends on q8gdp_pkg for the payload types and widths.
module q8_checker
	import q8gdp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [GSIZE_W-1:0] cfg_wdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  in_item_t           in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  out_item_t          out_data,
	output int                 errors,
	output int                 pending,
	output int                 rows_checked
);

	localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ACC_LO = -ACC_HI - 1;

	logic [GSIZE_W-1:0] gsize_shadow;
	int unsigned        grp_cnt;
	logic [GSUM_W-1:0]  grp_sum;
	longint             row_acc;
	bit                 row_clip;
	out_item_t          row_results[$];

	task automatic report(string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		errors++;
	endtask

	// Fold one element pair into the group sum; close the group and the row as needed.
	task automatic take_pair(in_item_t it);
		int          prod;
		int unsigned eff;
		longint      gsum;
		logic [63:0] mag;
		logic [63:0] scaled;
		logic [63:0] rnd;
		longint      acc;
		out_item_t   res;
		prod = $signed(it.act_value) * $signed(it.weight_value);
		grp_sum = grp_sum + prod[GSUM_W-1:0];
		grp_cnt++;
		eff = (gsize_shadow == 0 || gsize_shadow > MAX_GROUP_DEF) ? MAX_GROUP_DEF : gsize_shadow;
		if (grp_cnt >= eff) begin
			gsum = $signed(grp_sum);
			mag = (gsum < 0) ? -gsum : gsum;
			scaled = mag * 64'(it.act_scale) * 64'(it.weight_scale);
			// Q4.28 down to 16 fractional bits, ties away from zero (done on magnitude)
			rnd = (scaled + 64'd2048) >> 12;
			acc = row_acc + ((gsum < 0) ? -longint'(rnd) : longint'(rnd));
			if (acc > ACC_HI) begin
				acc = ACC_HI;
				row_clip = 1'b1;
			end else if (acc < ACC_LO) begin
				acc = ACC_LO;
				row_clip = 1'b1;
			end
			row_acc = acc;
			grp_cnt = 0;
			grp_sum = '0;
		end
		if (it.row_end) begin
			res.row_sum = row_acc[ROW_W-1:0];
			res.saturated = row_clip;
			row_results.push_back(res);
			grp_cnt = 0;
			grp_sum = '0;
			row_acc = 0;
			row_clip = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			gsize_shadow = GSIZE_RST;
			grp_cnt = 0;
			grp_sum = '0;
			row_acc = 0;
			row_clip = 1'b0;
			row_results.delete();
			errors = 0;
			rows_checked = 0;
		end else begin
			if (cfg_we)
				gsize_shadow = cfg_wdata;
			if (in_valid && !in_stall)
				take_pair(in_data);
			if (out_valid && !out_stall) begin
				if (row_results.size() == 0) begin
					report($sformatf("row result %0d/%0b with no row pending",
						out_data.row_sum, out_data.saturated));
				end else begin
					want = row_results.pop_front();
					if (out_data.row_sum !== want.row_sum)
						report($sformatf("row_sum %0d, expected %0d",
							out_data.row_sum, want.row_sum));
					if (out_data.saturated !== want.saturated)
						report($sformatf("saturated %0b, expected %0b",
							out_data.saturated, want.saturated));
					rows_checked++;
				end
			end
		end
		pending = row_results.size();
	end

endmodule

// ===== sim/tb_top.sv =====
// Top of the q8_group_dot_product testbench: clock, reset, group length writes, request
// stimulus and output stalls; q8_checker does the prediction and hands back a failure count.
// Depends on q8gdp_pkg, q8_group_dot_product and q8_checker.
module tb_top;
	import q8gdp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 160;
	localparam int SETTLE_CYCLES  = 10;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [GSIZE_W-1:0] cfg_wdata = '0;
	logic               in_valid  = 1'b0;
	in_item_t           in_data   = '0;
	logic               out_stall = 1'b0;
	logic               in_stall;
	logic               out_valid;
	out_item_t          out_data;

	int                 errors;
	int                 pending;
	int                 rows_checked;
	int                 sent = 0;
	int                 quiet_cycles = 0;
	bit                 idle_on = 1'b1;
	bit                 hold_req = 1'b0;
	logic [GSIZE_W-1:0] gsize_now = GSIZE_RST;

	always #2 clk = ~clk;

	q8_group_dot_product u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	q8_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.errors       (errors),
		.pending      (pending),
		.rows_checked (rows_checked)
	);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Output side: random stall bursts, plus one long hold-off on request.
	initial begin : receiver
		int n;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (n = 1; n < HOLD_CYCLES; n++)
					@(negedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				n = $urandom_range(1, 7);
				repeat (n - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic signed [7:0] pick_int8();
		case ($urandom_range(0, 9))
			0: return 8'sh80;
			1: return 8'sh7F;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [SCALE_W-1:0] pick_scale();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 16'h4000;
			default: return SCALE_W'($urandom);
		endcase
	endfunction

	function automatic in_item_t rand_pair();
		in_item_t it;
		it.act_value = pick_int8();
		it.weight_value = pick_int8();
		it.act_scale = pick_scale();
		it.weight_scale = pick_scale();
		it.row_end = 1'b0;
		return it;
	endfunction

	// Mostly whole groups per row; the rest have any length and may leave a partial group at row end.
	function automatic int row_len(logic [GSIZE_W-1:0] g);
		int eff;
		eff = (g == 0 || g > MAX_GROUP_DEF) ? MAX_GROUP_DEF : g;
		if ($urandom_range(0, 9) < 7)
			return eff * $urandom_range(1, 3);
		return $urandom_range(1, 3 * eff + 2);
	endfunction

	task automatic put_item(in_item_t it);
		int n;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 7);
			repeat (n) begin
				@(negedge clk);
				in_valid <= 1'b0;
				in_data <= rand_pair();
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic put_fields(logic signed [7:0] a, logic signed [7:0] w,
		logic [SCALE_W-1:0] as, logic [SCALE_W-1:0] ws, logic last);
		in_item_t it;
		it.act_value = a;
		it.weight_value = w;
		it.act_scale = as;
		it.weight_scale = ws;
		it.row_end = last;
		put_item(it);
	endtask

	task automatic send_row(int len);
		in_item_t it;
		for (int i = 0; i < len; i++) begin
			it = rand_pair();
			it.row_end = (i == len - 1);
			put_item(it);
		end
	endtask

	// Block goes idle: no request offered, every row back, and the pipe empty.
	task automatic drain_rows();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_group_size(logic [GSIZE_W-1:0] v);
		drain_rows();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		gsize_now = v;
	endtask

	task automatic random_phase(logic [GSIZE_W-1:0] g, int n_items);
		int start;
		set_group_size(g);
		start = sent;
		while (sent - start < n_items) begin
			idle_on = ($urandom_range(0, 3) != 0);
			send_row(row_len(gsize_now));
		end
		idle_on = 1'b1;
	endtask

	initial begin : stimulus
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// reset group length: one whole group, then a row with only a partial group
		send_row(32);
		send_row(6);

		// one element per group: extremes, zero scales, rounding ties
		set_group_size(9'd1);
		put_fields(-128, -128, 16'hFFFF, 16'hFFFF, 1'b1);
		put_fields(-128, 127, 16'hFFFF, 16'hFFFF, 1'b1);
		put_fields(127, 127, 16'h0000, 16'hFFFF, 1'b1);
		put_fields(0, -128, 16'hFFFF, 16'h0000, 1'b1);
		put_fields(1, 1, 16'd2048, 16'd1, 1'b1);
		put_fields(-1, 1, 16'd2048, 16'd1, 1'b1);
		put_fields(1, 1, 16'd2047, 16'd1, 1'b1);
		put_fields(-1, 1, 16'd2047, 16'd1, 1'b0);
		put_fields(127, -1, 16'd4000, 16'd3, 1'b0);
		put_fields(5, -7, 16'h4000, 16'h4000, 1'b1);
		put_fields(1, 1, 16'h4000, 16'h4000, 1'b1);

		// row end inside a group, on a group end, and with only a partial group
		set_group_size(9'd3);
		put_fields(10, 20, 16'h4000, 16'h2000, 1'b0);
		put_fields(-3, 4, 16'h1234, 16'hFFFF, 1'b0);
		put_fields(7, 7, 16'h4000, 16'h4000, 1'b0);
		put_fields(1, 2, 16'hFFFF, 16'hFFFF, 1'b0);
		put_fields(3, 3, 16'hFFFF, 16'hFFFF, 1'b1);
		for (int i = 0; i < 6; i++)
			put_fields((i % 2) ? 8'sh7F : 8'sh80, 8'sh80, 16'hFFFF, 16'h8001, i == 5);
		put_fields(100, 100, 16'hFFFF, 16'hFFFF, 1'b1);

		// lengths outside 1..256 behave as 256
		set_group_size(9'd0);
		send_row(4);
		set_group_size(9'd257);
		send_row(257);
		set_group_size(9'd511);
		send_row(4);

		for (int p = 0; p < 2; p++)
			random_phase(GSIZE_W'($urandom_range(1, 8)), 15);

		// output held off while short rows keep coming: the request queue fills up
		set_group_size(9'd2);
		idle_on = 1'b0;
		hold_req = 1'b1;
		repeat (12) send_row(2);
		idle_on = 1'b1;

		random_phase(GSIZE_W'($urandom_range(1, 8)), 15);

		// closing stretch with no idling on either side
		set_group_size(GSIZE_W'($urandom_range(1, 6)));
		idle_on = 1'b0;
		repeat (4) send_row(row_len(gsize_now));

		drain_rows();
		$display("Run covered %0d requests and %0d row results: group lengths 1, 2, 3, 32",
			sent, rows_checked);
		$display("and small random ones, lengths outside 1..256, partial groups, rounding ties,");
		$display("and a long output hold-off that fills the request queue.");
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
